@@ rtl/core/avs_pkg.sv @@
// package: shared constants for the angular vertex sorter
`default_nettype none
package avs_pkg;
  localparam int unsigned IDX_BITS = 5;
  localparam int unsigned IN_TDATA_BITS = 64;
  localparam int unsigned OUT_TDATA_BITS = 8;
endpackage
`default_nettype wire

@@ rtl/core/angular_vertex_sort.sv @@
// top level: angular vertex sorter
// Vertices stream in one transfer per cycle while the face is loading; the transfer
// with in_tlast set starts the sort. The sort first computes, one vertex a cycle, the
// scaled direction N*p - sum into a direction memory, then runs an insertion sort
// whose compares go through a shared pair of 32 x 32 bit multipliers that build the
// two 64 x 64 bit cross products from four partial products, one a cycle. Indices
// are then emitted one at a time, each held until it has been taken. The input is not
// ready until the last index has been taken. Vertices beyond MAX_VERTICES are dropped
// and out_tuser is set on every index of that run.
`default_nettype none
module angular_vertex_sort #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [avs_pkg::IN_TDATA_BITS-1:0] in_tdata,   // x_coord[31:0], y_coord[63:32]
  input  wire logic       in_tlast,    // last_vertex
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [avs_pkg::OUT_TDATA_BITS-1:0] out_tdata,  // vertex_index[4:0], zero fill
  output logic            out_tlast,   // last_out
  output logic            out_tuser    // overflow
);
  localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int DW = 64;

  typedef enum logic [3:0] {
    S_LOAD, S_DIR, S_OUTER, S_FETCH, S_WAIT, S_M0, S_M1, S_M2, S_M3, S_M4,
    S_DEC, S_PLACE, S_EMIT_RD, S_EMIT_WAIT, S_EMIT
  } state_t;

  state_t state_r;
  logic [AW-1:0] ord_mem [MAX_VERTICES];
  logic signed [31:0] xs_mem [MAX_VERTICES];
  logic signed [31:0] ys_mem [MAX_VERTICES];
  logic signed [DW-1:0] dx_mem [MAX_VERTICES];
  logic signed [DW-1:0] dy_mem [MAX_VERTICES];

  logic [CNTW-1:0] cnt_r;
  logic signed [DW-1:0] sx_r, sy_r;
  logic drop_r;
  logic [CNTW-1:0] i_r, j_r;
  logic signed [DW-1:0] ax_r, ay_r, rdx_r, rdy_r;
  logic signed [31:0] rxs_r, rys_r;
  logic [AW-1:0] rord_r;
  logic [127:0] acc_p_r, acc_q_r;
  logic neg_p_r, neg_q_r;
  logic [63:0] ua_r, ub_r, uc_r, ud_r;
  logic [7:0] odata_r;
  logic olast_r, ouser_r, ovalid_r;

  logic signed [CW-1:0] xn, yn;
  assign xn = in_tdata[CW-1:0];
  assign yn = in_tdata[32+CW-1:32];

  function automatic logic [63:0] uabs(input logic signed [63:0] v);
    uabs = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // shared unit: one 32x32 partial product per cycle for each of two cross terms
  logic [1:0] sel;
  logic [31:0] pa, pb, qa, qb;
  logic [63:0] pp, qp;
  always_comb begin
    sel = 2'd0;
    unique case (state_r)
      S_M2: sel = 2'd1;
      S_M3: sel = 2'd2;
      S_M4: sel = 2'd3;
      default: sel = 2'd0;
    endcase
    pa = sel[1] ? ua_r[63:32] : ua_r[31:0];
    pb = sel[0] ? ub_r[63:32] : ub_r[31:0];
    qa = sel[1] ? uc_r[63:32] : uc_r[31:0];
    qb = sel[0] ? ud_r[63:32] : ud_r[31:0];
  end
  assign pp = 64'(pa) * 64'(pb);
  assign qp = 64'(qa) * 64'(qb);

  // class: 0 lower half, 1 upper half, 2 angle pi
  function automatic logic [1:0] hcls(input logic signed [63:0] x, input logic signed [63:0] y);
    if (y < 0) hcls = 2'd0;
    else if (y > 0) hcls = 2'd1;
    else hcls = (x < 0) ? 2'd2 : 2'd1;
  endfunction

  logic signed [63:0] ax_e, bx_e;
  logic [1:0] ca, cb;
  assign ax_e = (ax_r == 0 && ay_r == 0) ? 64'sd1 : ax_r;
  assign bx_e = (rdx_r == 0 && rdy_r == 0) ? 64'sd1 : rdx_r;
  assign ca = hcls(ax_e, ay_r);
  assign cb = hcls(bx_e, rdy_r);

  logic [127:0] ps, qs;
  assign ps = neg_p_r ? 128'(-acc_p_r) : acc_p_r;
  assign qs = neg_q_r ? 128'(-acc_q_r) : acc_q_r;
  logic less;
  assign less = {~ps[127], ps[126:0]} > {~qs[127], qs[126:0]};
  // current vertex goes before the one at j-1
  logic move;
  assign move = (ca != cb) ? (ca < cb) : (ca != 2'd2 && less);

  logic in_fire, out_fire;
  assign in_tready = (state_r == S_LOAD);
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;
  assign out_tuser = ouser_r;

  logic signed [DW-1:0] nsx, nsy;
  assign nsx = sx_r + DW'(xn);
  assign nsy = sy_r + DW'(yn);
  logic [AW-1:0] ia, ja, jm1;
  assign ia = i_r[AW-1:0];
  assign ja = j_r[AW-1:0];
  assign jm1 = AW'(j_r - CNTW'(1));

  // memories
  always_ff @(posedge clk) begin
    if (in_fire && cnt_r < CNTW'(MAX_VERTICES)) begin
      xs_mem[cnt_r[AW-1:0]] <= 32'(xn);
      ys_mem[cnt_r[AW-1:0]] <= 32'(yn);
    end
    rxs_r <= xs_mem[ia];
    rys_r <= ys_mem[ia];
    if (state_r == S_DIR && i_r != 0) begin
      dx_mem[AW'(i_r - CNTW'(1))] <= DW'($signed({1'b0, cnt_r}) * rxs_r) - sx_r;
      dy_mem[AW'(i_r - CNTW'(1))] <= DW'($signed({1'b0, cnt_r}) * rys_r) - sy_r;
    end
    rord_r <= ord_mem[(state_r == S_EMIT_RD || state_r == S_EMIT) ? ia : jm1];
    rdx_r <= dx_mem[(state_r == S_OUTER) ? ia : rord_r];
    rdy_r <= dy_mem[(state_r == S_OUTER) ? ia : rord_r];
    if (state_r == S_DEC && j_r != 0 && move) ord_mem[ja] <= rord_r;
    if (state_r == S_PLACE) ord_mem[ja] <= ia;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0;
      sx_r <= '0;
      sy_r <= '0;
      drop_r <= 1'b0;
      ovalid_r <= 1'b0;
      i_r <= '0;
      j_r <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (cnt_r < CNTW'(MAX_VERTICES)) begin
              cnt_r <= cnt_r + CNTW'(1);
              sx_r <= nsx;
              sy_r <= nsy;
            end else drop_r <= 1'b1;
            if (in_tlast) begin
              state_r <= S_DIR;
              i_r <= '0;
            end
          end
        end
        S_DIR: begin
          // registered read: write i-1 while reading i
          if (i_r == cnt_r) begin
            state_r <= S_OUTER;
            i_r <= '0;
          end else i_r <= i_r + CNTW'(1);
        end
        S_OUTER: begin
          if (i_r == cnt_r) begin
            state_r <= S_EMIT_RD;
            i_r <= '0;
          end else begin
            j_r <= i_r;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          // the current vertex is latched only on entry from the outer loop
          if (j_r == i_r) begin
            ax_r <= rdx_r;
            ay_r <= rdy_r;
          end
          state_r <= (j_r == 0) ? S_PLACE : S_WAIT;
        end
        S_WAIT: state_r <= S_M0;
        S_M0: begin
          ua_r <= uabs(ax_e);
          ub_r <= uabs(rdy_r);
          uc_r <= uabs(ay_r);
          ud_r <= uabs(bx_e);
          neg_p_r <= ax_e[63] ^ rdy_r[63];
          neg_q_r <= ay_r[63] ^ bx_e[63];
          acc_p_r <= '0;
          acc_q_r <= '0;
          state_r <= S_M1;
        end
        S_M1: begin
          acc_p_r <= acc_p_r + 128'(pp);
          acc_q_r <= acc_q_r + 128'(qp);
          state_r <= S_M2;
        end
        S_M2: begin
          acc_p_r <= acc_p_r + (128'(pp) << 32);
          acc_q_r <= acc_q_r + (128'(qp) << 32);
          state_r <= S_M3;
        end
        S_M3: begin
          acc_p_r <= acc_p_r + (128'(pp) << 32);
          acc_q_r <= acc_q_r + (128'(qp) << 32);
          state_r <= S_M4;
        end
        S_M4: begin
          acc_p_r <= acc_p_r + (128'(pp) << 64);
          acc_q_r <= acc_q_r + (128'(qp) << 64);
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (move) begin
            j_r <= j_r - CNTW'(1);
            state_r <= (j_r == CNTW'(1)) ? S_PLACE : S_FETCH;
          end else state_r <= S_PLACE;
        end
        S_PLACE: begin
          i_r <= i_r + CNTW'(1);
          state_r <= S_OUTER;
        end
        S_EMIT_RD: state_r <= S_EMIT_WAIT;
        S_EMIT_WAIT: begin
          odata_r <= 8'(5'(rord_r));
          olast_r <= (i_r + CNTW'(1) == cnt_r);
          ouser_r <= drop_r;
          ovalid_r <= 1'b1;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_fire) begin
            ovalid_r <= 1'b0;
            if (i_r + CNTW'(1) == cnt_r) begin
              state_r <= S_LOAD;
              cnt_r <= '0;
              sx_r <= '0;
              sy_r <= '0;
              drop_r <= 1'b0;
            end else begin
              i_r <= i_r + CNTW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ verif/avs_checker.sv @@
// checker: watches both channels, predicts the sorted index runs and compares them
`timescale 1ns / 100ps
`default_nettype none
module avs_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        out_tuser,
  output int               errors,
  output int               pending
);
  localparam int CAP = 32;

  typedef struct packed {
    logic [avs_pkg::IDX_BITS-1:0] idx;
    logic                         last;
    logic                         ovf;
  } sorted_entry_t;

  sorted_entry_t expected_run[$];
  longint        face_x[CAP];
  longint        face_y[CAP];
  int            face_count;
  longint        face_sum_x;
  longint        face_sum_y;
  bit            face_dropped;

  // 0: lower half, 1: upper half incl. positive x axis, 2: negative x axis
  function automatic int half_plane(longint dx, longint dy);
    if (dy < 0) return 0;
    if (dy > 0) return 1;
    return (dx < 0) ? 2 : 1;
  endfunction

  function automatic bit angle_before(longint ax, longint ay, longint bx, longint by);
    int ha, hb;
    logic signed [127:0] wax, way, wbx, wby;
    if (ax == 0 && ay == 0) ax = 1;
    if (bx == 0 && by == 0) bx = 1;
    ha = half_plane(ax, ay);
    hb = half_plane(bx, by);
    if (ha != hb) return ha < hb;
    if (ha == 2) return 1'b0;
    wax = ax; way = ay; wbx = bx; wby = by;
    return (wax * wby) > (way * wbx);
  endfunction

  // sort the stored face by angle and queue its index run
  task automatic sort_face();
    longint dir_x[CAP];
    longint dir_y[CAP];
    int     order[CAP];
    int     cur, j;
    sorted_entry_t e;
    for (int i = 0; i < face_count; i++) begin
      dir_x[i] = longint'(face_count) * face_x[i] - face_sum_x;
      dir_y[i] = longint'(face_count) * face_y[i] - face_sum_y;
    end
    for (int i = 0; i < face_count; i++) begin
      cur = i;
      j = i;
      while (j > 0 && angle_before(dir_x[cur], dir_y[cur],
                                   dir_x[order[j-1]], dir_y[order[j-1]])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < face_count; i++) begin
      e.idx  = order[i][4:0];
      e.last = (i == face_count - 1);
      e.ovf  = face_dropped;
      expected_run = {expected_run, e};
    end
    face_count = 0;
    face_sum_x = 0;
    face_sum_y = 0;
    face_dropped = 0;
  endtask

  always @(posedge clk) begin
    sorted_entry_t want;
    if (!rst_n) begin
      errors = 0;
      pending = 0;
      face_count = 0;
      face_sum_x = 0;
      face_sum_y = 0;
      face_dropped = 0;
      expected_run.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_run.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected index transfer: idx %0d last %0b ovf %0b",
                     out_tdata[4:0], out_tlast, out_tuser);
        end else begin
          want = expected_run.pop_front();
          if (out_tdata !== {3'b000, want.idx} || out_tlast !== want.last ||
              out_tuser !== want.ovf) begin
            errors++;
            if (errors <= 10)
              $display("index mismatch: expected idx %0d last %0b ovf %0b, got data %0h last %0b ovf %0b",
                       want.idx, want.last, want.ovf, out_tdata, out_tlast, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (face_count < CAP) begin
          face_x[face_count] = longint'($signed(in_tdata[31:0]));
          face_y[face_count] = longint'($signed(in_tdata[63:32]));
          face_sum_x += face_x[face_count];
          face_sum_y += face_y[face_count];
          face_count++;
        end else begin
          face_dropped = 1;
        end
        if (in_tlast) sort_face();
      end
      pending = expected_run.size();
    end
  end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench top: vertex stimulus, receiver stalls and verdict for the angular vertex sorter
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // x_coord[31:0], y_coord[63:32]
  logic        in_tlast;   // last_vertex
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // vertex_index[4:0], zero fill
  logic        out_tlast;  // last_out
  logic        out_tuser;  // overflow
  int          errors;
  int          pending;
  int          vertices_sent;
  int          burst_left;
  logic        hold_off;   // long receiver hold-off in progress
  logic        hold_go;    // asks the hold-off process to start

  angular_vertex_sort uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  avs_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .errors(errors), .pending(pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: a random stall style, long hold-off overrides
  int rx_cycle = 0;
  int rx_style = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_style <= $urandom_range(0, 2);
    if (hold_off)
      out_tready <= 1'b0;
    else case (rx_style)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // long hold-off, counted here while the sender keeps offering vertices
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (6000) @(posedge clk);
    hold_off <= 1'b0;
  end

  // one vertex transfer; sender runs in bursts with random gaps
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    vertices_sent++;
  endtask

  function automatic logic [31:0] pick_coord(int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8)) - 4) << 16;   // small grid, many ties
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_face(int n);
    int style;
    style = $urandom_range(0, 2);
    for (int i = 0; i < n; i++)
      send_vertex(pick_coord(style), pick_coord(style), i == n - 1);
  endtask

  initial begin
    int n, faces;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    hold_go = 1'b0;
    vertices_sent = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single vertex face
    send_vertex(32'h0001_0000, 32'hffff_0000, 1'b1);
    // coordinate extremes
    send_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    // centroid vertex, negative x axis (angle pi), equal angles kept in load order
    send_vertex(32'd0, 32'd0, 1'b0);
    send_vertex(-32'sd4, 32'd0, 1'b0);
    send_vertex(32'd4, 32'd0, 1'b0);
    send_vertex(32'd2, 32'd0, 1'b0);
    send_vertex(32'd0, 32'd4, 1'b0);
    send_vertex(32'd0, -32'sd4, 1'b0);
    send_vertex(-32'sd2, 32'd0, 1'b1);
    // all vertices coincident
    send_vertex(32'd7, 32'd7, 1'b0);
    send_vertex(32'd7, 32'd7, 1'b1);

    // sender waits for the block to drain completely
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);

    faces = 0;
    while (vertices_sent < 200) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(33, 36);   // beyond capacity
        1, 2:    n = $urandom_range(13, 32);
        default: n = $urandom_range(2, 12);
      endcase
      if (faces == 2) hold_go <= 1'b1;
      if (faces == 6) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      send_face(n);
      faces++;
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/avs_pkg.sv
rtl/core/angular_vertex_sort.sv
verif/avs_checker.sv
verif/tb_top.sv
